### hw/rtl/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types, kind codes and character classes for the script tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int OffsetBits = 16;
  localparam int KeywordChars = 6;
  localparam int MaxTokens = 3;

  localparam logic [15:0] LenMax = 16'hFFFF;

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_WORD, M_INT, M_DOT, M_FRAC, M_STR, M_OP, M_DOLLAR, M_DOLVAR
  } mode_t;

  localparam logic [5:0] K_EOF = 6'd0;
  localparam logic [5:0] K_IDENT = 6'd1;
  localparam logic [5:0] K_NUMBER = 6'd2;
  localparam logic [5:0] K_STRING = 6'd3;
  localparam logic [5:0] K_LPAREN = 6'd4;
  localparam logic [5:0] K_RPAREN = 6'd5;
  localparam logic [5:0] K_COLON = 6'd6;
  localparam logic [5:0] K_SEMI = 6'd7;
  localparam logic [5:0] K_COMMA = 6'd8;
  localparam logic [5:0] K_PRINT = 6'd9;
  localparam logic [5:0] K_CARET = 6'd10;
  localparam logic [5:0] K_PERCENT = 6'd11;
  localparam logic [5:0] K_ASSIGN = 6'd12;
  localparam logic [5:0] K_EQEQ = 6'd13;
  localparam logic [5:0] K_NE_OP = 6'd14;
  localparam logic [5:0] K_BANG = 6'd15;
  localparam logic [5:0] K_LE_OP = 6'd16;
  localparam logic [5:0] K_LT_OP = 6'd17;
  localparam logic [5:0] K_GE_OP = 6'd18;
  localparam logic [5:0] K_GT_OP = 6'd19;
  localparam logic [5:0] K_MINUSEQ = 6'd20;
  localparam logic [5:0] K_MINUS = 6'd21;
  localparam logic [5:0] K_PLUSEQ = 6'd22;
  localparam logic [5:0] K_PLUS = 6'd23;
  localparam logic [5:0] K_STAREQ = 6'd24;
  localparam logic [5:0] K_STAR = 6'd25;
  localparam logic [5:0] K_SLASHEQ = 6'd26;
  localparam logic [5:0] K_SLASH = 6'd27;
  localparam logic [5:0] K_ANDAND = 6'd28;
  localparam logic [5:0] K_AND = 6'd29;
  localparam logic [5:0] K_DOTDOT = 6'd30;
  localparam logic [5:0] K_DOT = 6'd31;
  localparam logic [5:0] K_PIPE2 = 6'd32;
  localparam logic [5:0] K_PIPE = 6'd33;
  localparam logic [5:0] K_REGISTER = 6'd34;
  localparam logic [5:0] K_DOLLAR = 6'd35;
  localparam logic [5:0] K_BREAK = 6'd36;
  localparam logic [5:0] K_DONE = 6'd37;
  localparam logic [5:0] K_ELSE = 6'd38;
  localparam logic [5:0] K_EQ = 6'd39;
  localparam logic [5:0] K_FOR = 6'd40;
  localparam logic [5:0] K_GTE = 6'd41;
  localparam logic [5:0] K_GT = 6'd42;
  localparam logic [5:0] K_IF = 6'd43;
  localparam logic [5:0] K_LTE = 6'd44;
  localparam logic [5:0] K_LT = 6'd45;
  localparam logic [5:0] K_NIL = 6'd46;
  localparam logic [5:0] K_NE = 6'd47;
  localparam logic [5:0] K_OF = 6'd48;
  localparam logic [5:0] K_RETURN = 6'd49;
  localparam logic [5:0] K_SUB = 6'd50;
  localparam logic [5:0] K_TIME = 6'd51;
  localparam logic [5:0] K_UNTIL = 6'd52;
  localparam logic [5:0] K_VAR = 6'd53;
  localparam logic [5:0] K_WHILE = 6'd54;
  localparam logic [5:0] K_BADCHAR = 6'd55;
  localparam logic [5:0] K_UNTERM = 6'd56;

  localparam logic [2:0] R_ARROW = 3'd0;
  localparam logic [2:0] R_PIPE = 3'd1;
  localparam logic [2:0] R_SPADE = 3'd2;
  localparam logic [2:0] R_HEART = 3'd3;
  localparam logic [2:0] R_CLUB = 3'd4;
  localparam logic [2:0] R_DIAMOND = 3'd5;

  typedef struct packed {
    logic [7:0] arrow;
    logic [7:0] pipe;
    logic [7:0] spade;
    logic [7:0] heart;
    logic [7:0] club;
    logic [7:0] diamond;
  } codes_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  line;
  } token_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_wordc(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "." || c == 8'd164;
  endfunction

  // keyword lookup over the stored prefix; word length decides the candidates
  function automatic logic [5:0] word_kind(input logic [KeywordChars*8-1:0] w,
                                          input logic [15:0] n);
    logic [47:0] s;
    logic [5:0]  k;
    s = w[47:0];
    k = K_IDENT;
    case (n)
      16'd2: begin
        case (s[15:0])
          {"q", "e"}: k = K_EQ;
          {"t", "g"}: k = K_GT;
          {"f", "i"}: k = K_IF;
          {"t", "l"}: k = K_LT;
          {"e", "n"}: k = K_NE;
          {"f", "o"}: k = K_OF;
          default: k = K_IDENT;
        endcase
      end
      16'd3: begin
        case (s[23:0])
          {"r", "o", "f"}: k = K_FOR;
          {"e", "t", "g"}: k = K_GTE;
          {"e", "t", "l"}: k = K_LTE;
          {"l", "i", "n"}: k = K_NIL;
          {"b", "u", "s"}: k = K_SUB;
          {"r", "a", "v"}: k = K_VAR;
          default: k = K_IDENT;
        endcase
      end
      16'd4: begin
        case (s[31:0])
          {"e", "n", "o", "d"}: k = K_DONE;
          {"e", "s", "l", "e"}: k = K_ELSE;
          {"e", "m", "i", "t"}: k = K_TIME;
          default: k = K_IDENT;
        endcase
      end
      16'd5: begin
        case (s[39:0])
          {"k", "a", "e", "r", "b"}: k = K_BREAK;
          {"t", "n", "i", "r", "p"}: k = K_PRINT;
          {"l", "i", "t", "n", "u"}: k = K_UNTIL;
          {"e", "l", "i", "h", "w"}: k = K_WHILE;
          default: k = K_IDENT;
        endcase
      end
      16'd6: begin
        if (s == {"n", "r", "u", "t", "e", "r"}) k = K_RETURN;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

### hw/rtl/stok_regs.sv
// ----------------------------------------------------------------------------
// stok_regs
// Configuration register file with an APB-style write and read port.
// ----------------------------------------------------------------------------
module stok_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output stok_pkg::codes_t     codes
);
  import stok_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.arrow <= 8'd95;
      codes.pipe <= 8'd221;
      codes.spade <= 8'd193;
      codes.heart <= 8'd211;
      codes.club <= 8'd216;
      codes.diamond <= 8'd218;
    end else if (wr && paddr[1:0] == 2'd0) begin
      case (idx)
        R_ARROW: codes.arrow <= pwdata[7:0];
        R_PIPE: codes.pipe <= pwdata[7:0];
        R_SPADE: codes.spade <= pwdata[7:0];
        R_HEART: codes.heart <= pwdata[7:0];
        R_CLUB: codes.club <= pwdata[7:0];
        R_DIAMOND: codes.diamond <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      R_ARROW: prdata = {24'd0, codes.arrow};
      R_PIPE: prdata = {24'd0, codes.pipe};
      R_SPADE: prdata = {24'd0, codes.spade};
      R_HEART: prdata = {24'd0, codes.heart};
      R_CLUB: prdata = {24'd0, codes.club};
      R_DIAMOND: prdata = {24'd0, codes.diamond};
      default: prdata = 32'd0;
    endcase
  end

endmodule

### hw/rtl/stok_outq.sv
// ----------------------------------------------------------------------------
// stok_outq
// Token queue: up to three tokens in a cycle, one word out a cycle if tready.
// ----------------------------------------------------------------------------
module stok_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [1:0]         push_count,
  input  stok_pkg::token_t   push_tok [stok_pkg::MaxTokens],
  output logic               has_room,
  output logic               tvalid,
  input  logic               tready,
  output logic               tlast,
  output stok_pkg::token_t   tok
);
  import stok_pkg::*;

  // eight slots: room for one full burst while a second one drains
  token_t     q [8];
  logic       ql [8];
  logic [2:0] rd;
  logic [2:0] wp;
  logic [3:0] cnt;
  logic       pop;
  logic [3:0] cnt_next;

  assign pop = tvalid && tready;
  assign tvalid = cnt != 4'd0;
  assign tok = q[rd];
  assign tlast = ql[rd];
  assign has_room = cnt <= 4'd5;
  assign cnt_next = cnt + (push ? {2'd0, push_count} : 4'd0) - {3'd0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0;
      wp <= '0;
      cnt <= '0;
    end else begin
      if (pop) rd <= rd + 3'd1;
      if (push) wp <= wp + {1'b0, push_count};
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < MaxTokens; i++) begin
        if (2'(i) < push_count) begin
          q[wp + 3'(i)] <= push_tok[i];
          ql[wp + 3'(i)] <= (2'(i) == push_count - 2'd1);
        end
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> cnt <= 4'd5) else $error("token queue overflow");
  a_last_present: assert property (@(posedge clk) disable iff (rst)
    (cnt == 4'd1 && tvalid) |-> tlast) else $error("lone word not last");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !push && pop |=> cnt == $past(cnt) - 4'd1) else $error("bad drain");

endmodule

### hw/rtl/stok_scan.sv
// ----------------------------------------------------------------------------
// stok_scan
// Scanner state and per-byte next-state and token logic.
// ----------------------------------------------------------------------------
module stok_scan (
  input  logic               clk,
  input  logic               rst,
  input  stok_pkg::codes_t   codes,
  input  logic               step,
  input  logic [7:0]         c,
  input  logic               eos,
  output logic [1:0]         n_tok,
  output stok_pkg::token_t   tok [stok_pkg::MaxTokens]
);
  import stok_pkg::*;

  mode_t       mode, mode_next;
  logic [15:0] tbeg, tbeg_next;
  logic [15:0] pos, pos_next;
  logic [15:0] tlen, tlen_next;
  logic [7:0]  line, line_next;
  logic [7:0]  pend, pend_next;
  logic [7:0]  qterm, qterm_next;
  logic [7:0]  wp [KeywordChars];
  logic        wp_we;
  logic [2:0]  wp_idx;
  logic [KeywordChars*8-1:0] wflat;

  always_comb begin
    for (int i = 0; i < KeywordChars; i++) wflat[i*8 +: 8] = wp[i];
  end

  function automatic logic [15:0] inc(input logic [15:0] v);
    return (v == LenMax) ? v : v + 16'd1;
  endfunction

  always_comb begin
    logic [15:0] p;
    logic [7:0]  sec;
    logic [5:0]  two, one;
    logic        do_fresh;
    logic [7:0]  fc;
    p = pos;
    mode_next = mode;
    tbeg_next = tbeg;
    pos_next = pos;
    tlen_next = tlen;
    line_next = line;
    pend_next = pend;
    qterm_next = qterm;
    wp_we = 1'b0;
    wp_idx = '0;
    n_tok = '0;
    do_fresh = 1'b0;
    fc = c;
    for (int i = 0; i < MaxTokens; i++) tok[i] = '{K_EOF, 16'd0, 16'd0, line};

    sec = "=";
    case (pend)
      "=": begin two = K_EQEQ; one = K_ASSIGN; end
      "!": begin two = K_NE_OP; one = K_BANG; end
      "<": begin two = K_LE_OP; one = K_LT_OP; end
      ">": begin two = K_GE_OP; one = K_GT_OP; end
      "-": begin two = K_MINUSEQ; one = K_MINUS; end
      "+": begin two = K_PLUSEQ; one = K_PLUS; end
      "*": begin two = K_STAREQ; one = K_STAR; end
      "/": begin two = K_SLASHEQ; one = K_SLASH; end
      "&": begin sec = "&"; two = K_ANDAND; one = K_AND; end
      ".": begin sec = "."; two = K_DOTDOT; one = K_DOT; end
      default: begin sec = codes.pipe; two = K_PIPE2; one = K_PIPE; end
    endcase

    if (eos) begin
      case (mode)
        M_WORD: begin tok[0] = '{word_kind(wflat, tlen), tbeg, tlen, line}; n_tok = 2'd1; end
        M_INT, M_FRAC: begin tok[0] = '{K_NUMBER, tbeg, tlen, line}; n_tok = 2'd1; end
        M_DOT: begin
          tok[0] = '{K_NUMBER, tbeg, tlen, line};
          tok[1] = '{K_DOT, pos - 16'd1, 16'd1, line};
          n_tok = 2'd2;
        end
        M_STR: begin tok[0] = '{K_UNTERM, 16'd0, 16'd0, line}; n_tok = 2'd1; end
        M_OP: begin tok[0] = '{one, tbeg, 16'd1, line}; n_tok = 2'd1; end
        M_DOLLAR: begin tok[0] = '{K_DOLLAR, tbeg, 16'd1, line}; n_tok = 2'd1; end
        M_DOLVAR: begin tok[0] = '{K_IDENT, tbeg, tlen, line}; n_tok = 2'd1; end
        default: ;
      endcase
      tok[n_tok] = '{K_EOF, p, 16'd0, line};
      n_tok = n_tok + 2'd1;
      mode_next = M_IDLE;
      pos_next = '0;
      tbeg_next = '0;
      line_next = 8'd1;
    end else begin
      pos_next = p + 16'd1;
      case (mode)
        M_COMMENT: if (c == 8'h0A) do_fresh = 1'b1;
        M_WORD: begin
          if (is_wordc(c)) begin
            if (tlen < 16'(KeywordChars)) begin wp_we = 1'b1; wp_idx = tlen[2:0]; end
            tlen_next = inc(tlen);
          end else if (tlen == 16'd1 && wp[0] == "q") begin
            qterm_next = c; tlen_next = inc(tlen); mode_next = M_STR;
          end else begin
            tok[0] = '{word_kind(wflat, tlen), tbeg, tlen, line}; n_tok = 2'd1;
            do_fresh = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(c)) tlen_next = inc(tlen);
          else if (c == ".") mode_next = M_DOT;
          else begin tok[0] = '{K_NUMBER, tbeg, tlen, line}; n_tok = 2'd1; do_fresh = 1'b1; end
        end
        M_DOT: begin
          if (is_digit(c)) begin
            tlen_next = inc(inc(tlen)); mode_next = M_FRAC;
          end else begin
            tok[0] = '{K_NUMBER, tbeg, tlen, line};
            n_tok = 2'd1;
            tbeg_next = p - 16'd1;
            tlen_next = 16'd1;
            pend_next = ".";
            if (c == ".") begin
              tok[1] = '{K_DOTDOT, p - 16'd1, 16'd2, line}; n_tok = 2'd2; mode_next = M_IDLE;
            end else begin
              tok[1] = '{K_DOT, p - 16'd1, 16'd1, line}; n_tok = 2'd2; do_fresh = 1'b1;
            end
          end
        end
        M_FRAC: begin
          if (is_digit(c)) tlen_next = inc(tlen);
          else begin tok[0] = '{K_NUMBER, tbeg, tlen, line}; n_tok = 2'd1; do_fresh = 1'b1; end
        end
        M_STR: begin
          tlen_next = inc(tlen);
          if (c == qterm) begin
            tok[0] = '{K_STRING, tbeg, inc(tlen), line}; n_tok = 2'd1; mode_next = M_IDLE;
          end else if (c == 8'h0A) line_next = line + 8'd1;
        end
        M_OP: begin
          if (c == sec) begin
            tok[0] = '{two, tbeg, 16'd2, line}; n_tok = 2'd1; mode_next = M_IDLE;
          end else begin
            tok[0] = '{one, tbeg, 16'd1, line}; n_tok = 2'd1; do_fresh = 1'b1;
          end
        end
        M_DOLLAR: begin
          if (is_alpha(c)) begin tlen_next = inc(tlen); mode_next = M_DOLVAR; end
          else begin tok[0] = '{K_DOLLAR, tbeg, 16'd1, line}; n_tok = 2'd1; do_fresh = 1'b1; end
        end
        M_DOLVAR: begin
          if (is_wordc(c)) tlen_next = inc(tlen);
          else begin tok[0] = '{K_IDENT, tbeg, tlen, line}; n_tok = 2'd1; do_fresh = 1'b1; end
        end
        default: do_fresh = 1'b1;
      endcase

      // start a new token on this byte
      if (do_fresh) begin
        mode_next = M_IDLE;
        if (!is_space(fc)) begin
          tbeg_next = p;
          tlen_next = 16'd1;
          if (fc == "#") mode_next = M_COMMENT;
          else if (is_alpha(fc)) begin wp_we = 1'b1; wp_idx = '0; mode_next = M_WORD; end
          else if (is_digit(fc)) mode_next = M_INT;
          else begin
            case (fc)
              "(": begin tok[n_tok] = '{K_LPAREN, p, 16'd1, line}; n_tok = n_tok + 2'd1; end
              ")": begin tok[n_tok] = '{K_RPAREN, p, 16'd1, line}; n_tok = n_tok + 2'd1; end
              ":": begin tok[n_tok] = '{K_COLON, p, 16'd1, line}; n_tok = n_tok + 2'd1; end
              ";": begin tok[n_tok] = '{K_SEMI, p, 16'd1, line}; n_tok = n_tok + 2'd1; end
              ",": begin tok[n_tok] = '{K_COMMA, p, 16'd1, line}; n_tok = n_tok + 2'd1; end
              "?": begin tok[n_tok] = '{K_PRINT, p, 16'd1, line}; n_tok = n_tok + 2'd1; end
              "^": begin tok[n_tok] = '{K_CARET, p, 16'd1, line}; n_tok = n_tok + 2'd1; end
              "%": begin tok[n_tok] = '{K_PERCENT, p, 16'd1, line}; n_tok = n_tok + 2'd1; end
              "\"", "'": begin qterm_next = fc; mode_next = M_STR; end
              "=", "!", "<", ">", "-", "+", "*", "/", "&", ".": begin
                pend_next = fc; mode_next = M_OP;
              end
              "$": mode_next = M_DOLLAR;
              default: begin
                if (fc == codes.arrow) begin
                  tok[n_tok] = '{K_ASSIGN, p, 16'd1, line}; n_tok = n_tok + 2'd1;
                end else if (fc == codes.pipe) begin
                  pend_next = fc; mode_next = M_OP;
                end else if (fc == codes.spade || fc == codes.heart ||
                             fc == codes.club || fc == codes.diamond) begin
                  tok[n_tok] = '{K_REGISTER, p, 16'd1, line}; n_tok = n_tok + 2'd1;
                end else begin
                  tok[n_tok] = '{K_BADCHAR, 16'd0, 16'd0, line}; n_tok = n_tok + 2'd1;
                end
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      tbeg <= '0;
      pos <= '0;
      tlen <= '0;
      line <= 8'd1;
      pend <= '0;
      qterm <= '0;
    end else if (step) begin
      mode <= mode_next;
      tbeg <= tbeg_next;
      pos <= pos_next;
      tlen <= tlen_next;
      line <= line_next;
      pend <= pend_next;
      qterm <= qterm_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && !eos && wp_we) wp[wp_idx] <= c;
  end

  a_eos_resets: assert property (@(posedge clk) disable iff (rst)
    step && eos |=> pos == 16'd0 && line == 8'd1) else $error("end mark did not restart");
  a_eos_emits: assert property (@(posedge clk) disable iff (rst)
    step && eos |-> n_tok != 2'd0) else $error("end mark without EOF word");
  a_pos_adv: assert property (@(posedge clk) disable iff (rst)
    step && !eos |=> pos == $past(pos) + 16'd1) else $error("position not advanced");

endmodule

### hw/rtl/script_tokenizer.sv
// ----------------------------------------------------------------------------
// script_tokenizer
// Streaming tokenizer: one source byte per word in, token words out.
// ----------------------------------------------------------------------------
// Tokens of an accepted byte are registered in the token queue, then leave in order.
// Throughput: one byte per cycle while the token queue has room; a byte that yields
// n tokens gives n words, one at a time, from the queue's single-word output port.
// Reset: synchronous; clears scanner (line 1, offset 0) and queue; presets the codes.
module script_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] source_byte
  input  logic        s_tlast,   // end_of_source
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [5:0] token_kind, [21:6] token_start,
                                 // [37:22] token_length, [45:38] token_line, zero fill
  output logic        m_tlast    // last_of_run
);
  import stok_pkg::*;

  codes_t     codes;
  logic       step;
  logic [1:0] n_tok;
  token_t     toks [MaxTokens];
  token_t     otok;
  logic       room;

  assign pready = 1'b1;
  assign step = s_tvalid && s_tready;
  assign s_tready = room;
  assign m_tdata = {2'b00, otok.line, otok.length, otok.start, otok.kind};

  stok_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .codes
  );

  stok_scan u_scan (
    .clk, .rst, .codes, .step, .c(s_tdata), .eos(s_tlast), .n_tok, .tok(toks)
  );

  stok_outq u_outq (
    .clk, .rst, .push(step && n_tok != 2'd0), .push_count(n_tok), .push_tok(toks),
    .has_room(room), .tvalid(m_tvalid), .tready(m_tready), .tlast(m_tlast), .tok(otok)
  );

endmodule
